// ----- rtl/core/cossim_pkg.sv -----
`timescale 1ns / 1ps

package cossim_pkg;

   // vector length limit and the widths that follow from it
   localparam int MAX_DIM = 4096;
   localparam int PAIR_W  = $clog2(MAX_DIM + 1);
   localparam int ELEM_W  = 16;
   localparam int SUM_W   = 32 + $clog2(MAX_DIM);
   localparam int PROD_W  = 2 * SUM_W;

   // quotient 2^32 * dot^2 / (xe * ye) never exceeds 2^32
   localparam int QUO_W  = 33;
   localparam int ROOT_W = 17;
   localparam int SIM_W  = 16;

   localparam int MUL_STEPS  = SUM_W;
   localparam int DIV_STEPS  = QUO_W;
   localparam int SQRT_STEPS = (QUO_W + 1) / 2;
   localparam int STEP_MAX   = (MUL_STEPS > DIV_STEPS) ? MUL_STEPS : DIV_STEPS;
   localparam int STEP_W     = $clog2(STEP_MAX);

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ZERO     = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_CHECK,
      ST_MUL,
      ST_DIV_LOAD,
      ST_DIV,
      ST_SQRT_LOAD,
      ST_SQRT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic clear;
   } acc_cmd_type;

   typedef struct packed {
      logic overflowed;
      logic energy_zero;
   } acc_stat_type;

   typedef struct packed {
      logic       load_mul;
      logic       mul_step;
      logic       load_div;
      logic       div_step;
      logic       load_sqrt;
      logic       sqrt_step;
      logic       emit;
      status_type status;
   } mag_cmd_type;

endpackage

// ----- rtl/core/cosine_similarity_core.sv -----
`timescale 1ns / 1ps

// cosine similarity of two vectors streamed as element pairs
// req channel: one word per element pair, x and y in signed q1.15, req_tlast on the final pair
// rsp channel: one word per vector pair, similarity in signed q1.15 and a status code
//   status 0 ok, 1 one vector has zero magnitude, 2 more than the supported element count
//   similarity is zero whenever status is nonzero, +1.0 saturates to 32767
// throughput: one pair per cycle inside a vector, the accumulators take a pair every cycle
// after the last pair req_tready drops while the result is worked out:
//   the check state, then for a good result 44 multiply steps (shift-add, two products),
//   1 + 33 divide steps and 1 + 17 square root steps, then the emit state, which waits
//   while an earlier result is still not taken; error results go from check straight to emit
// the sums clear in the check state, so the next vector may start right after the result
// a result waiting for rsp_tready does not block new pairs; only the next emit waits for it
// reset clears the sums, the pair count, the overflow flag and the output valid
module cosine_similarity_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // x_element [15:0], y_element [31:16]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // similarity [15:0]
   output logic [1:0]  rsp_tuser    // status [1:0]
);

   cossim_pkg::acc_cmd_type  acc_cmd;
   cossim_pkg::acc_stat_type acc_stat;
   cossim_pkg::mag_cmd_type  mag_cmd;
   logic                     out_busy;

   logic [cossim_pkg::SUM_W-1:0]        x_energy;
   logic [cossim_pkg::SUM_W-1:0]        y_energy;
   logic signed [cossim_pkg::SUM_W-1:0] cross_sum;

   // sequencer: accepts pairs and walks the multiply, divide and root steps
   cossim_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .acc_stat   (acc_stat),
      .out_busy   (out_busy),
      .acc_cmd    (acc_cmd),
      .mag_cmd    (mag_cmd)
   );

   // running sums of x*x, y*y and x*y
   cossim_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .acc_cmd   (acc_cmd),
      .x_element ($signed(req_tdata[15:0])),
      .y_element ($signed(req_tdata[31:16])),
      .x_energy  (x_energy),
      .y_energy  (y_energy),
      .cross_sum (cross_sum),
      .acc_stat  (acc_stat)
   );

   // rounded 32768 * dot / sqrt(xe * ye) and the output word register
   cossim_magnitude u_magnitude (
      .clock      (clock),
      .reset      (reset),
      .cmd        (mag_cmd),
      .x_energy   (x_energy),
      .y_energy   (y_energy),
      .cross_sum  (cross_sum),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .out_busy   (out_busy)
   );

endmodule

// ----- rtl/core/cossim_accum.sv -----
`timescale 1ns / 1ps

module cossim_accum (
   input  logic                                clock,
   input  logic                                reset,
   input  cossim_pkg::acc_cmd_type             acc_cmd,
   input  logic signed [cossim_pkg::ELEM_W-1:0] x_element,
   input  logic signed [cossim_pkg::ELEM_W-1:0] y_element,
   output logic [cossim_pkg::SUM_W-1:0]        x_energy,
   output logic [cossim_pkg::SUM_W-1:0]        y_energy,
   output logic signed [cossim_pkg::SUM_W-1:0] cross_sum,
   output cossim_pkg::acc_stat_type            acc_stat
);

   logic [cossim_pkg::SUM_W-1:0]          x_energy_ff, x_energy_in;
   logic [cossim_pkg::SUM_W-1:0]          y_energy_ff, y_energy_in;
   logic signed [cossim_pkg::SUM_W-1:0]   cross_sum_ff, cross_sum_in;
   logic [cossim_pkg::PAIR_W-1:0]         pair_count_ff, pair_count_in;
   logic                                  overflowed_ff, overflowed_in;
   logic signed [2*cossim_pkg::ELEM_W-1:0] xx, yy, xy;
   logic                                  full;

   always_comb begin
      xx = x_element * x_element;
      yy = y_element * y_element;
      xy = x_element * y_element;
      full = (pair_count_ff >= cossim_pkg::PAIR_W'(cossim_pkg::MAX_DIM));

      x_energy_in   = x_energy_ff;
      y_energy_in   = y_energy_ff;
      cross_sum_in  = cross_sum_ff;
      pair_count_in = pair_count_ff;
      overflowed_in = overflowed_ff;

      if (acc_cmd.clear) begin
         x_energy_in   = '0;
         y_energy_in   = '0;
         cross_sum_in  = '0;
         pair_count_in = '0;
         overflowed_in = 1'b0;
      end else if (acc_cmd.accept) begin
         if (full) begin
            overflowed_in = 1'b1;
         end else begin
            x_energy_in   = x_energy_ff + cossim_pkg::SUM_W'($unsigned(xx));
            y_energy_in   = y_energy_ff + cossim_pkg::SUM_W'($unsigned(yy));
            cross_sum_in  = cross_sum_ff + cossim_pkg::SUM_W'(xy);
            pair_count_in = pair_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_energy_ff   <= '0;
         y_energy_ff   <= '0;
         cross_sum_ff  <= '0;
         pair_count_ff <= '0;
         overflowed_ff <= 1'b0;
      end else begin
         x_energy_ff   <= x_energy_in;
         y_energy_ff   <= y_energy_in;
         cross_sum_ff  <= cross_sum_in;
         pair_count_ff <= pair_count_in;
         overflowed_ff <= overflowed_in;
      end
   end

   assign x_energy             = x_energy_ff;
   assign y_energy             = y_energy_ff;
   assign cross_sum            = cross_sum_ff;
   assign acc_stat.overflowed  = overflowed_ff;
   assign acc_stat.energy_zero = (x_energy_ff == '0) || (y_energy_ff == '0);

endmodule

// ----- rtl/core/cossim_magnitude.sv -----
`timescale 1ns / 1ps

module cossim_magnitude (
   input  logic                                clock,
   input  logic                                reset,
   input  cossim_pkg::mag_cmd_type             cmd,
   input  logic [cossim_pkg::SUM_W-1:0]        x_energy,
   input  logic [cossim_pkg::SUM_W-1:0]        y_energy,
   input  logic signed [cossim_pkg::SUM_W-1:0] cross_sum,
   input  logic                                rsp_tready,
   output logic                                rsp_tvalid,
   output logic [cossim_pkg::SIM_W-1:0]        rsp_tdata,
   output logic [1:0]                          rsp_tuser,
   output logic                                out_busy
);

   localparam int PW = cossim_pkg::PROD_W;
   localparam int SW = cossim_pkg::SUM_W;
   localparam int QW = cossim_pkg::QUO_W;

   // shift-add multipliers: xe * ye and |dot| * |dot|
   logic [PW-1:0] pe_ff, pe_in, pd_ff, pd_in;
   logic [PW-1:0] me_ff, me_in, md_ff, md_in;
   logic [SW-1:0] re_ff, re_in, rd_ff, rd_in;
   logic          neg_ff, neg_in;
   // restoring divider
   logic [PW-1:0] rem_ff, rem_in;
   logic [QW-1:0] dbits_ff, dbits_in;
   logic [QW-1:0] quo_ff, quo_in;
   // digit-by-digit square root
   logic [QW-1:0] num_ff, num_in, res_ff, res_in, bit_ff, bit_in;
   // output word
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [cossim_pkg::SIM_W-1:0]  sim_ff, sim_in;
   cossim_pkg::status_type        status_ff, status_in;

   logic [SW-1:0]                 adot;
   logic [PW:0]                   shifted, diff;
   logic [QW:0]                   trial;
   logic [cossim_pkg::ROOT_W:0]   root_inc;
   logic [cossim_pkg::SIM_W-1:0]  mag;

   always_comb begin
      adot     = cross_sum[SW-1] ? SW'(-cross_sum) : SW'(cross_sum);
      shifted  = {rem_ff, dbits_ff[QW-1]};
      diff     = shifted - {1'b0, pe_ff};
      trial    = {1'b0, res_ff} + {1'b0, bit_ff};
      root_inc = {1'b0, res_ff[cossim_pkg::ROOT_W-1:0]} + 1'b1;
      mag      = root_inc[cossim_pkg::SIM_W:1];

      pe_in = pe_ff; pd_in = pd_ff; me_in = me_ff; md_in = md_ff;
      re_in = re_ff; rd_in = rd_ff; neg_in = neg_ff;
      rem_in = rem_ff; dbits_in = dbits_ff; quo_in = quo_ff;
      num_in = num_ff; res_in = res_ff; bit_in = bit_ff;
      sim_in = sim_ff; status_in = status_ff;

      if (cmd.load_mul) begin
         pe_in  = '0;
         pd_in  = '0;
         me_in  = PW'(x_energy);
         md_in  = PW'(adot);
         re_in  = y_energy;
         rd_in  = adot;
         neg_in = cross_sum[SW-1];
      end
      if (cmd.mul_step) begin
         if (re_ff[0]) pe_in = pe_ff + me_ff;
         if (rd_ff[0]) pd_in = pd_ff + md_ff;
         me_in = me_ff << 1;
         md_in = md_ff << 1;
         re_in = re_ff >> 1;
         rd_in = rd_ff >> 1;
      end

      // dividend is dot^2 * 2^32, the top part preloads the remainder
      if (cmd.load_div) begin
         rem_in   = pd_ff >> 1;
         dbits_in = {pd_ff[0], {(QW-1){1'b0}}};
         quo_in   = '0;
      end
      if (cmd.div_step) begin
         dbits_in = dbits_ff << 1;
         if (!diff[PW]) begin
            rem_in = diff[PW-1:0];
            quo_in = {quo_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = shifted[PW-1:0];
            quo_in = {quo_ff[QW-2:0], 1'b0};
         end
      end

      if (cmd.load_sqrt) begin
         num_in = quo_ff;
         res_in = '0;
         bit_in = {1'b1, {(QW-1){1'b0}}};
      end
      if (cmd.sqrt_step) begin
         bit_in = bit_ff >> 2;
         if ({1'b0, num_ff} >= trial) begin
            num_in = QW'({1'b0, num_ff} - trial);
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
      end

      // largest odd t with t^2 <= quotient gives k = (root + 1) / 2
      if (cmd.emit) begin
         status_in = cmd.status;
         if (cmd.status != cossim_pkg::STATUS_OK) begin
            sim_in = '0;
         end else if (neg_ff) begin
            sim_in = -mag;
         end else if (mag[cossim_pkg::SIM_W-1]) begin
            sim_in = {1'b0, {(cossim_pkg::SIM_W-1){1'b1}}};
         end else begin
            sim_in = mag;
         end
      end

      if (cmd.emit) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      pe_ff <= pe_in;   pd_ff <= pd_in;
      me_ff <= me_in;   md_ff <= md_in;
      re_ff <= re_in;   rd_ff <= rd_in;
      neg_ff <= neg_in;
      rem_ff <= rem_in; dbits_ff <= dbits_in; quo_ff <= quo_in;
      num_ff <= num_in; res_ff <= res_in; bit_ff <= bit_in;
      sim_ff <= sim_in; status_ff <= status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = sim_ff;
   assign rsp_tuser  = status_ff;
   assign out_busy   = rsp_valid_ff && !rsp_tready;

endmodule

// ----- rtl/core/cossim_ctrl.sv -----
`timescale 1ns / 1ps

module cossim_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   input  logic                         req_tlast,
   output logic                         req_tready,
   input  cossim_pkg::acc_stat_type     acc_stat,
   input  logic                         out_busy,
   output cossim_pkg::acc_cmd_type      acc_cmd,
   output cossim_pkg::mag_cmd_type      mag_cmd
);

   localparam int CW = cossim_pkg::STEP_W;

   cossim_pkg::state_type  state_ff, state_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   cossim_pkg::status_type status_ff, status_in;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      status_in  = status_ff;
      req_tready = 1'b0;
      acc_cmd    = '0;
      mag_cmd    = '0;
      mag_cmd.status = status_ff;

      unique case (state_ff)
         cossim_pkg::ST_ACCUM: begin
            req_tready     = 1'b1;
            acc_cmd.accept = req_tvalid;
            if (req_tvalid && req_tlast) state_in = cossim_pkg::ST_CHECK;
         end
         cossim_pkg::ST_CHECK: begin
            acc_cmd.clear = 1'b1;
            cnt_in        = '0;
            if (acc_stat.overflowed) begin
               status_in = cossim_pkg::STATUS_OVERFLOW;
               state_in  = cossim_pkg::ST_EMIT;
            end else if (acc_stat.energy_zero) begin
               status_in = cossim_pkg::STATUS_ZERO;
               state_in  = cossim_pkg::ST_EMIT;
            end else begin
               status_in        = cossim_pkg::STATUS_OK;
               mag_cmd.load_mul = 1'b1;
               state_in         = cossim_pkg::ST_MUL;
            end
         end
         cossim_pkg::ST_MUL: begin
            mag_cmd.mul_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(cossim_pkg::MUL_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = cossim_pkg::ST_DIV_LOAD;
            end
         end
         cossim_pkg::ST_DIV_LOAD: begin
            mag_cmd.load_div = 1'b1;
            state_in = cossim_pkg::ST_DIV;
         end
         cossim_pkg::ST_DIV: begin
            mag_cmd.div_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(cossim_pkg::DIV_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = cossim_pkg::ST_SQRT_LOAD;
            end
         end
         cossim_pkg::ST_SQRT_LOAD: begin
            mag_cmd.load_sqrt = 1'b1;
            state_in = cossim_pkg::ST_SQRT;
         end
         cossim_pkg::ST_SQRT: begin
            mag_cmd.sqrt_step = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(cossim_pkg::SQRT_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = cossim_pkg::ST_EMIT;
            end
         end
         cossim_pkg::ST_EMIT: begin
            if (!out_busy) begin
               mag_cmd.emit = 1'b1;
               state_in     = cossim_pkg::ST_ACCUM;
            end
         end
         default: begin
            state_in = cossim_pkg::ST_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= cossim_pkg::ST_ACCUM;
         cnt_ff    <= '0;
         status_ff <= cossim_pkg::STATUS_OK;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         status_ff <= status_in;
      end
   end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

   // running sums and expected results for the cosine similarity of paired vectors
   class cossim_scoreboard_type;
      logic [cossim_pkg::SUM_W-1:0]        x_energy;
      logic [cossim_pkg::SUM_W-1:0]        y_energy;
      logic signed [cossim_pkg::SUM_W-1:0] cross_sum;
      int unsigned                         pair_count;
      bit                                  overflowed;
      logic [cossim_pkg::SIM_W-1:0]        sim_queue[$];
      cossim_pkg::status_type              status_queue[$];
      int unsigned                         errors;

      function new();
         errors = 0;
         clear_sums();
      endfunction

      function void clear_sums();
         x_energy   = '0;
         y_energy   = '0;
         cross_sum  = '0;
         pair_count = 0;
         overflowed = 1'b0;
      endfunction

      function int pending();
         return sim_queue.size();
      endfunction

      // largest k in 0..32768 with (2k-1)^2 * xe * ye <= 2^32 * dot^2,
      // which is 32768 * |cos| rounded to nearest, ties away from zero
      function logic [16:0] rounded_cosine(logic [cossim_pkg::SUM_W-1:0] xe,
                                           logic [cossim_pkg::SUM_W-1:0] ye,
                                           logic [cossim_pkg::SUM_W-1:0] adot);
         logic [127:0] energy_prod;
         logic [127:0] dot_scaled;
         logic [127:0] odd;
         logic [127:0] lhs;
         logic [16:0]  lo;
         logic [16:0]  hi;
         logic [16:0]  k;
         energy_prod = xe;
         energy_prod = energy_prod * ye;
         dot_scaled  = adot;
         dot_scaled  = (dot_scaled * dot_scaled) << 32;
         lo = '0;
         hi = 17'd32768;
         while (lo < hi) begin
            k   = (lo + hi + 17'd1) >> 1;
            odd = k;
            odd = 2 * odd - 1;
            lhs = energy_prod * odd * odd;
            if (lhs <= dot_scaled) begin
               lo = k;
            end else begin
               hi = k - 17'd1;
            end
         end
         return lo;
      endfunction

      // one accepted pair; a last pair books one expected result word
      function void note_pair(logic signed [15:0] x, logic signed [15:0] y, logic last);
         logic signed [31:0]           xx;
         logic signed [31:0]           yy;
         logic signed [31:0]           xy;
         logic [cossim_pkg::SUM_W-1:0] adot;
         logic [16:0]                  k;
         logic [cossim_pkg::SIM_W-1:0] sim;
         cossim_pkg::status_type       status;
         if (pair_count >= cossim_pkg::MAX_DIM) begin
            overflowed = 1'b1;
         end else begin
            xx = x * x;
            yy = y * y;
            xy = x * y;
            x_energy   = x_energy + xx;
            y_energy   = y_energy + yy;
            cross_sum  = cross_sum + xy;
            pair_count = pair_count + 1;
         end
         if (!last) return;
         sim    = '0;
         status = cossim_pkg::STATUS_OK;
         if (overflowed) begin
            status = cossim_pkg::STATUS_OVERFLOW;
         end else if (x_energy == 0 || y_energy == 0) begin
            status = cossim_pkg::STATUS_ZERO;
         end else begin
            adot = (cross_sum < 0) ? -cross_sum : cross_sum;
            k    = rounded_cosine(x_energy, y_energy, adot);
            if (cross_sum < 0) begin
               sim = -k;
            end else begin
               sim = (k > 17'd32767) ? 16'h7fff : k[15:0];
            end
         end
         sim_queue.push_back(sim);
         status_queue.push_back(status);
         clear_sums();
      endfunction

      task report_mismatch(string what);
         errors++;
         if (errors <= 100) $display("mismatch at %0t: %s", $time, what);
      endtask

      task check_result(logic [cossim_pkg::SIM_W-1:0] sim, logic [1:0] status);
         logic [cossim_pkg::SIM_W-1:0] want_sim;
         cossim_pkg::status_type       want_status;
         if (sim_queue.size() == 0) begin
            report_mismatch($sformatf("result word with none pending, similarity %0d status %0d",
                                      $signed(sim), status));
         end else begin
            want_sim    = sim_queue.pop_front();
            want_status = status_queue.pop_front();
            if (status != want_status)
               report_mismatch($sformatf("status %0d, expected %0d", status, want_status));
            if (sim != want_sim)
               report_mismatch($sformatf("similarity %0d, expected %0d",
                                         $signed(sim), $signed(want_sim)));
         end
      endtask
   endclass

   typedef enum int {
      FILL_RANDOM,
      FILL_SMALL,
      FILL_SAME,
      FILL_OPPOSITE,
      FILL_ZERO_X,
      FILL_ZERO_Y,
      FILL_EXTREME
   } fill_type;

   localparam int RANDOM_PAIRS = 1780;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // x_element [15:0], y_element [31:16]
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // similarity [15:0]
   logic [1:0]  rsp_tuser;         // status [1:0]

   // when set, neither side idles
   bit calm = 1'b0;

   cossim_scoreboard_type book;

   cosine_similarity_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #20_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // idle cycles before the next word: mostly none or short, now and then long
   function int idle_cycles();
      int r;
      r = $urandom_range(99, 0);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(3, 1);
      if (r < 98) return $urandom_range(12, 4);
      return $urandom_range(60, 20);
   endfunction

   // drive one pair word at the falling edge, hold until taken at a rising edge
   task send_pair(logic signed [15:0] x, logic signed [15:0] y, logic last);
      int gap;
      gap = idle_cycles();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {y, x};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      book.note_pair(x, y, last);
      @(negedge clock);
   endtask

   function logic signed [15:0] extreme_value();
      case ($urandom_range(5, 0))
         0:       return -16'sd32768;
         1:       return 16'sd32767;
         2:       return 16'sd0;
         3:       return -16'sd1;
         4:       return 16'sd1;
         default: return 16'sh4000;
      endcase
   endfunction

   // one vector pair of the given length, element values shaped by the fill kind
   task send_vector(int len, fill_type fill);
      logic signed [15:0] x;
      logic signed [15:0] y;
      for (int i = 0; i < len; i++) begin
         x = $urandom;
         y = $urandom;
         case (fill)
            FILL_SMALL: begin
               x = $urandom_range(16, 0) - 8;
               y = $urandom_range(16, 0) - 8;
            end
            FILL_SAME:     y = x + ($urandom_range(6, 0) - 3);
            FILL_OPPOSITE: y = -x + ($urandom_range(6, 0) - 3);
            FILL_ZERO_X:   x = '0;
            FILL_ZERO_Y:   y = '0;
            FILL_EXTREME: begin
               x = extreme_value();
               y = extreme_value();
            end
            default: ;
         endcase
         send_pair(x, y, i == len - 1);
      end
   endtask

   // result side: ready runs and stalls of random length, sampled at the rising edge
   initial begin
      int hold;
      int r;
      hold = 0;
      forever begin
         @(negedge clock);
         if (calm) begin
            rsp_tready <= 1'b1;
            hold = 0;
         end else if (hold > 0) begin
            hold--;
         end else begin
            r = $urandom_range(99, 0);
            if (r < 60) begin
               rsp_tready <= 1'b1;
               hold = $urandom_range(20, 1);
            end else if (r < 90) begin
               rsp_tready <= 1'b0;
               hold = $urandom_range(4, 1);
            end else begin
               rsp_tready <= 1'b0;
               hold = $urandom_range(150, 20);
            end
         end
      end
   end

   // every accepted result word goes to the scoreboard
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) book.check_result(rsp_tdata, rsp_tuser);
      end
   end

   initial begin
      int       random_sent;
      int       len;
      int       r;
      fill_type fill;
      book = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single pairs: saturation at +1, exact -1, zero magnitude on either side
      send_pair(16'sd32767, 16'sd32767, 1'b1);
      send_pair(-16'sd32768, 16'sd32767, 1'b1);
      send_pair(-16'sd32768, -16'sd32768, 1'b1);
      send_pair(16'sd0, 16'sd1234, 1'b1);
      send_pair(-16'sd1234, 16'sd0, 1'b1);
      send_pair(16'sd0, 16'sd0, 1'b1);
      send_pair(16'sd1, -16'sd1, 1'b1);
      // orthogonal vectors give zero
      send_pair(16'sd1000, 16'sd0, 1'b0);
      send_pair(16'sd0, -16'sd1000, 1'b1);
      // mixed extremes, then a vector of small values
      send_pair(16'sd32767, -16'sd32768, 1'b0);
      send_pair(-16'sd32768, 16'sd32767, 1'b0);
      send_pair(16'sd1, -16'sd1, 1'b1);
      send_pair(16'sd3, 16'sd4, 1'b0);
      send_pair(16'sd4, -16'sd3, 1'b0);
      send_pair(-16'sd7, 16'sd5, 1'b1);

      // random vectors: mostly short, a few long, with assorted value shapes
      random_sent = 0;
      while (random_sent < RANDOM_PAIRS) begin
         r = $urandom_range(99, 0);
         if (r < 70) len = $urandom_range(8, 1);
         else if (r < 95) len = $urandom_range(40, 9);
         else len = $urandom_range(200, 41);
         r = $urandom_range(99, 0);
         if (r < 35) fill = FILL_RANDOM;
         else if (r < 50) fill = FILL_SMALL;
         else if (r < 65) fill = FILL_SAME;
         else if (r < 78) fill = FILL_OPPOSITE;
         else if (r < 83) fill = FILL_ZERO_X;
         else if (r < 88) fill = FILL_ZERO_Y;
         else fill = FILL_EXTREME;
         calm = ($urandom_range(5, 0) == 0);
         send_vector(len, fill);
         random_sent += len;
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      // drain, then allow for a stray late word
      while (book.pending() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (book.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ----- cosine_similarity_core.f -----
rtl/core/cossim_pkg.sv
rtl/core/cossim_accum.sv
rtl/core/cossim_magnitude.sv
rtl/core/cossim_ctrl.sv
rtl/core/cosine_similarity_core.sv
bench/testbench.sv
